// ===== sv/mfb_pkg.sv =====
`timescale 1ns / 1ps
package mfb_pkg;

  localparam int HEIGHT_W    = 11;
  localparam int WIDTH_W     = 13;
  localparam int RADIUS_W    = 2;
  localparam int WIDTH_LIMIT = 4096;
  localparam int PIX_W       = 8;
  // signed coordinate width for mirroring, covers WIDTH_LIMIT plus the radius
  localparam int MIR_W       = 15;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] median_out;
    logic             last_out;
  } out_item_t;

  // what one sort cell shows its upper neighbor
  typedef struct packed {
    logic             lt;
    logic             valid;
    logic [PIX_W-1:0] value;
  } cell_link_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SETTLE,
    ST_RESULT
  } state_t;

  // reflect with the edge pixel included, then clamp into the image
  function automatic logic signed [MIR_W-1:0] mirror(input logic signed [MIR_W-1:0] i,
                                                      input logic signed [MIR_W-1:0] n);
    logic signed [MIR_W-1:0] v;
    begin
      v = i;
      if (v < 0) v = -v - MIR_W'(1);
      if (v >= n) v = (n <<< 1) - MIR_W'(1) - v;
      if (v < 0) v = '0;
      if (v >= n) v = n - MIR_W'(1);
      return v;
    end
  endfunction

endpackage

// ===== sv/mfb_sort_cell.sv =====
`timescale 1ns / 1ps
module mfb_sort_cell
  import mfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             insert,
  input  logic [PIX_W-1:0] new_value,
  input  cell_link_t       below,
  output cell_link_t       self_link
);

  logic             valid;
  logic [PIX_W-1:0] value;
  logic             lt;

  // empty cells act as plus infinity
  assign lt = !valid || (new_value < value);
  assign self_link = '{lt: lt, valid: valid, value: value};

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (insert) begin
      if (below.lt) begin
        valid <= below.valid;
      end else if (lt) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      if (below.lt) begin
        value <= below.value;
      end else if (lt) begin
        value <= new_value;
      end
    end
  end

endmodule

// ===== sv/mfb_sort_chain.sv =====
`timescale 1ns / 1ps
module mfb_sort_chain
  import mfb_pkg::*;
#(
  parameter int N = 49
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 insert,
  input  logic [PIX_W-1:0]     new_value,
  input  logic [$clog2(N)-1:0] sel,
  output logic [PIX_W-1:0]     median
);

  cell_link_t links [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    cell_link_t below;
    if (g == 0) begin : g_first
      assign below = '{lt: 1'b0, valid: 1'b0, value: '0};
    end else begin : g_rest
      assign below = links[g-1];
    end
    mfb_sort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear),
      .insert    (insert),
      .new_value (new_value),
      .below     (below),
      .self_link (links[g])
    );
  end

  assign median = links[sel].value;

endmodule

// ===== sv/median_filter_mirror_border_unit.sv =====
`timescale 1ns / 1ps
// channel | signals                          | transfer when
// --------+----------------------------------+----------------------------
// input   | in_valid, in_stall, in_data      | in_valid && !in_stall
// output  | out_valid, out_stall, out_data   | out_valid && !out_stall
// config  | cfg_we, cfg_index, cfg_data      | cfg_we
//
// An item that completes no output only passes the readiness check; else one
// read of the column store per window pixel, each inserted into the sort
// chain. Reset clears counters and out_valid and loads default config; the
// column store is not cleared. A held result stalls only the final step.
module median_filter_mirror_border_unit
  import mfb_pkg::*;
#(
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data
);

  localparam int RING_BITS = $clog2(2 * MAX_RADIUS + 2);
  localparam int DEPTH     = (2 ** RING_BITS) * MAX_HEIGHT;
  localparam int AW        = $clog2(DEPTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int HT_W      = $clog2(MAX_HEIGHT + 1);
  localparam int R_W       = $clog2(MAX_RADIUS + 1);
  localparam int CELLS     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SEL_W     = $clog2(CELLS);

  // config registers
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  image_width;
  logic [RADIUS_W-1:0] window_radius;

  // stream positions
  logic [WIDTH_W-1:0] in_column, out_column;
  logic [ROW_W-1:0]   in_row, out_row;

  state_t state, state_next;

  // window walk
  logic signed [4:0] dc, dr;
  logic              rd_pending;
  logic [PIX_W-1:0]  rd_data;
  logic [AW-1:0]     rd_addr;

  logic [PIX_W-1:0] mem [DEPTH];

  logic [HT_W-1:0]    h_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [R_W-1:0]     r_eff;

  logic accept, store_pixel, ready, last, walk_done;
  logic clear_cells, issue, load_out;
  logic [PIX_W-1:0] median;
  logic [SEL_W-1:0] med_sel;

  logic signed [MIR_W-1:0] mir_col, mir_row;
  int need_c, need_r;

  // clamp the config registers into range
  always_comb begin
    if (image_height == '0) begin
      h_eff = HT_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = HT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HT_W'(image_height);
    end
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (int'(image_width) > WIDTH_LIMIT) begin
      w_eff = WIDTH_W'(WIDTH_LIMIT);
    end else begin
      w_eff = image_width;
    end
    if (int'(window_radius) > MAX_RADIUS) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = R_W'(window_radius);
    end
  end

  assign accept      = in_valid && !in_stall;
  assign store_pixel = accept && (in_data.kind == KIND_PIXEL) && (in_column < w_eff);

  // has the whole window of the next output arrived
  always_comb begin
    need_c = int'(out_column) + int'(r_eff);
    if (need_c > int'(w_eff) - 1) need_c = int'(w_eff) - 1;
    need_r = int'(out_row) + int'(r_eff);
    if (need_r > int'(h_eff) - 1) need_r = int'(h_eff) - 1;
    ready = (out_column < w_eff) &&
            ((int'(in_column) > need_c) ||
             ((int'(in_column) == need_c) && (int'(in_row) > need_r)));
  end

  assign last      = (int'(out_column) == int'(w_eff) - 1) &&
                     (int'(out_row) == int'(h_eff) - 1);
  assign walk_done = (dc == signed'(5'(r_eff))) && (dr == signed'(5'(r_eff)));
  assign med_sel   = SEL_W'(2 * int'(r_eff) * (int'(r_eff) + 1));

  // mirrored window position, mapped onto the column ring
  always_comb begin
    mir_col = mirror(signed'(MIR_W'(out_column)) + MIR_W'(dc), signed'(MIR_W'(w_eff)));
    mir_row = mirror(signed'(MIR_W'(out_row)) + MIR_W'(dr), signed'(MIR_W'(h_eff)));
    rd_addr = AW'(mir_col[RING_BITS-1:0]) * AW'(MAX_HEIGHT) + AW'(mir_row);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_CHECK;
      ST_CHECK:  state_next = ready ? ST_READ : ST_IDLE;
      ST_READ:   if (walk_done) state_next = ST_SETTLE;
      ST_SETTLE: state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall    = 1'b1;
    clear_cells = 1'b0;
    issue       = 1'b0;
    load_out    = 1'b0;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_CHECK:  clear_cells = ready;
      ST_READ:   issue = 1'b1;
      ST_SETTLE: ;
      ST_RESULT: load_out = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes; a write to a named register restarts the frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height  <= HEIGHT_W'(1024);
      image_width   <= WIDTH_W'(1024);
      window_radius <= RADIUS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT: image_height  <= cfg_data[HEIGHT_W-1:0];
        REG_WIDTH:  image_width   <= cfg_data;
        REG_RADIUS: window_radius <= cfg_data[RADIUS_W-1:0];
        default:    ;
      endcase
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_index == REG_HEIGHT || cfg_index == REG_WIDTH ||
                           cfg_index == REG_RADIUS))) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (load_out && last) begin
      // end of frame: start over
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      if (store_pixel) begin
        if (int'(in_row) + 1 >= int'(h_eff)) begin
          in_row    <= '0;
          in_column <= in_column + 1'b1;
        end else begin
          in_row <= in_row + 1'b1;
        end
      end
      if (load_out) begin
        if (int'(out_row) + 1 >= int'(h_eff)) begin
          out_row    <= '0;
          out_column <= out_column + 1'b1;
        end else begin
          out_row <= out_row + 1'b1;
        end
      end
    end
  end

  // walk the window, row offset fastest
  always_ff @(posedge clk) begin
    if (clear_cells) begin
      dc <= -signed'(5'(r_eff));
      dr <= -signed'(5'(r_eff));
    end else if (issue) begin
      if (dr == signed'(5'(r_eff))) begin
        dr <= -signed'(5'(r_eff));
        dc <= dc + 5'sd1;
      end else begin
        dr <= dr + 5'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= issue;
    end
  end

  // column store
  always_ff @(posedge clk) begin
    if (store_pixel) begin
      mem[AW'(in_column[RING_BITS-1:0]) * AW'(MAX_HEIGHT) + AW'(in_row)] <= in_data.pixel_in;
    end
    rd_data <= mem[rd_addr];
  end

  mfb_sort_chain #(
    .N (CELLS)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear_cells),
    .insert    (rd_pending),
    .new_value (rd_data),
    .sel       (med_sel),
    .median    (median)
  );

  // output register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= '{median_out: median, last_out: last};
    end
  end

endmodule

// ===== sv/mfb_checker.sv =====
`timescale 1ns / 1ps
module mfb_checker
  import mfb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_item_t            out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken before the first was processed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind median_filter_mirror_border_unit mfb_checker u_mfb_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import mfb_pkg::*;

  localparam int STORE_ROWS   = 1024;
  localparam int STORE_COLS   = 8;
  localparam int TOP_RADIUS   = 3;
  localparam int SETTLE_WAIT  = 120;      // longer than one full-window item
  localparam int CYCLE_LIMIT  = 3000000;
  // an index that names no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEIGHT;
  logic [WIDTH_W-1:0]   cfg_data = '0;

  median_filter_mirror_border_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // stimulus waiting for the driver, medians waiting for the block
  in_item_t  pending_pixels[$];
  out_item_t expected_medians[$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatches     = 0;
  int medians_seen   = 0;
  int items_sent     = 0;
  int frames_run     = 0;
  int cycles         = 0;
  bit in_fired       = 1'b0;

  // mirror copy of the filter state
  logic [PIX_W-1:0] pix_ring[0:STORE_COLS*STORE_ROWS-1];
  int in_col, in_row, out_col, out_row;
  int img_h = 1024, img_w = 1024, win_r = 1;

  function automatic int reflect(int i, int n);
    if (i < 0) i = -1 - i;
    if (i >= n) i = 2 * n - 1 - i;
    if (i < 0) i = 0;
    if (i >= n) i = n - 1;
    return i;
  endfunction

  function automatic void clear_positions();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, int val);
    case (idx)
      REG_HEIGHT: begin img_h = val & 'h7FF; clear_positions(); end
      REG_WIDTH:  begin img_w = val & 'h1FFF; clear_positions(); end
      REG_RADIUS: begin win_r = val & 'h3; clear_positions(); end
      default: ;
    endcase
  endfunction

  // advance the filter by one accepted transfer, queue a median if one is due
  function automatic void filter_step(in_item_t it);
    int h, w, r, need_c, need_r, n, c, row, v, j;
    int win[49];
    out_item_t res;
    h = (img_h == 0) ? 1 : (img_h > STORE_ROWS ? STORE_ROWS : img_h);
    w = (img_w == 0) ? 1 : (img_w > WIDTH_LIMIT ? WIDTH_LIMIT : img_w);
    r = (win_r > TOP_RADIUS) ? TOP_RADIUS : win_r;
    if (it.kind == KIND_PIXEL && in_col < w) begin
      pix_ring[(in_col % STORE_COLS) * STORE_ROWS + in_row] = it.pixel_in;
      in_row++;
      if (in_row >= h) begin in_row = 0; in_col++; end
    end
    if (out_col >= w) return;
    need_c = (out_col + r > w - 1) ? w - 1 : out_col + r;
    need_r = (out_row + r > h - 1) ? h - 1 : out_row + r;
    if (!(in_col > need_c || (in_col == need_c && in_row > need_r))) return;
    n = 0;
    for (int dc = -r; dc <= r; dc++) begin
      c = reflect(out_col + dc, w);
      for (int dr = -r; dr <= r; dr++) begin
        row = reflect(out_row + dr, h);
        v = int'(pix_ring[(c % STORE_COLS) * STORE_ROWS + row]);
        // insertion sort as the window fills
        j = n;
        while (j > 0 && win[j-1] > v) begin win[j] = win[j-1]; j--; end
        win[j] = v;
        n++;
      end
    end
    res.median_out = PIX_W'(win[n/2]);
    res.last_out = (out_col == w - 1) && (out_row == h - 1);
    expected_medians.push_back(res);
    if (res.last_out) clear_positions();
    else begin
      out_row++;
      if (out_row >= h) begin out_row = 0; out_col++; end
    end
  endfunction

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("median_filter_mirror_border_unit regression: fail");
      $finish;
    end
    in_fired = !rst && in_valid && !in_stall;
    if (in_fired) begin
      filter_step(in_data);
      items_sent++;
    end
    if (!rst && out_valid && !out_stall) begin
      medians_seen++;
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected median %0d last %0b", out_data.median_out, out_data.last_out);
      end else begin
        want = expected_medians.pop_front();
        if (want.median_out !== out_data.median_out || want.last_out !== out_data.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: expected %0d/%0b, got %0d/%0b", want.median_out,
                     want.last_out, out_data.median_out, out_data.last_out);
        end
      end
    end
  end

  // driver: change inputs on the falling edge; hold a payload until it transfers
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || in_fired) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[WIDTH_W-1:0];
    apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until the driver is empty and every median came back, then let it settle
  task automatic drain_and_settle();
    while (pending_pixels.size() != 0 || in_valid || expected_medians.size() != 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic void push_item(logic kind, int pix);
    in_item_t it;
    it.kind = kind;
    it.pixel_in = pix[PIX_W-1:0];
    pending_pixels.push_back(it);
  endfunction

  function automatic int rand_pixel();
    case ($urandom_range(3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // one frame: write all registers; broken: random pixels and drains,
  // else pixels, stray drains, maybe two past the image, flush drains
  task automatic run_frame(int h, int w, int r, bit broken);
    int cnt;
    drain_and_settle();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_RADIUS, r);
    frames_run++;
    if (broken) begin
      cnt = $urandom_range(1, 3 * h * w);
      repeat (cnt)
        push_item(($urandom_range(3) == 0) ? KIND_DRAIN : KIND_PIXEL, rand_pixel());
    end else begin
      for (int i = 0; i < h * w; i++) begin
        if ($urandom_range(5) == 0) push_item(KIND_DRAIN, $urandom_range(255));
        push_item(KIND_PIXEL, rand_pixel());
      end
      if ($urandom_range(1)) begin
        push_item(KIND_PIXEL, rand_pixel());
        push_item(KIND_PIXEL, rand_pixel());
      end
      repeat (h * w) push_item(KIND_DRAIN, $urandom_range(255));
    end
  endtask

  task automatic random_phase(int idle_pct, int stall);
    int start;
    drain_and_settle();
    send_idle_pct = idle_pct;
    stall_pct = stall;
    start = items_sent;
    while (items_sent + pending_pixels.size() - start < 160) begin
      run_frame($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(3),
                $urandom_range(7) == 0);
      while (pending_pixels.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: drain with nothing ready, then tiny and oversized windows
    push_item(KIND_DRAIN, 0);
    run_frame(1, 1, 0, 1'b0);
    run_frame(3, 3, 3, 1'b0);
    run_frame(2, 5, 2, 1'b0);
    // out-of-range register values act as their limits
    drain_and_settle();
    write_reg(REG_HEIGHT, 0);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_RADIUS, 3);
    push_item(KIND_PIXEL, 255);
    push_item(KIND_PIXEL, 7);
    push_item(KIND_DRAIN, 255);
    drain_and_settle();
    write_reg(REG_HEIGHT, 2047);
    write_reg(REG_WIDTH, 8191);
    write_reg(REG_RADIUS, 3);
    write_reg(REG_SPARE, 8191);
    for (int i = 0; i < 10; i++) push_item(KIND_PIXEL, (i & 1) ? 255 : i * 37);
    repeat (4) push_item(KIND_DRAIN, 170);

    random_phase(0, 0);
    random_phase(79, 0);
    random_phase(0, 79);
    random_phase(26, 26);
    drain_and_settle();

    $display("covered %0d input transfers over %0d frame setups, %0d medians checked",
             items_sent, frames_run, medians_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0)
      $display("median_filter_mirror_border_unit regression: pass");
    else
      $display("median_filter_mirror_border_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mfb_pkg.sv
sv/mfb_sort_cell.sv
sv/mfb_sort_chain.sv
sv/median_filter_mirror_border_unit.sv
sv/mfb_checker.sv
test/tb_top.sv
